// File: rtl/ctior_pkg.sv
// Shared types and constants for the processor discovery table.
// Used by ctior_cell and cpu_table_insert_or_refresh; no dependencies.
package ctior_pkg;

   localparam int ID_W                = 64;
   localparam int METH_W              = 8;
   localparam int SLOT_W              = 4;
   localparam int TOTAL_W             = 5;
   localparam int DEFAULT_TABLE_DEPTH = 16;
   localparam int CSR_DATA_W          = 32;
   localparam int CSR_ADDR_W          = 3;

   // register index, taken from the word address bit of paddr
   typedef enum logic [0:0] {
      REG_UNKNOWN_METHOD = 1'b0
   } csr_reg_type;

   // lookup transaction travelling down the row of cells
   typedef struct packed {
      logic              active;
      logic              done;      // matched or appended somewhere upstream
      logic              appended;  // a new entry was written
      logic [ID_W-1:0]   key;
      logic              en;
      logic              boot;
      logic [METH_W-1:0] meth;
   } token_type;

endpackage

// File: rtl/ctior_cell.sv
// One table slot: holds an entry and checks the passing transaction against it.
// Depends on ctior_pkg for token_type and field widths.
module ctior_cell
   import ctior_pkg::*;
#(
   parameter int CELL_INDEX = 0,
   parameter int CNT_W      = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [CNT_W-1:0]  entry_count,
   input  logic [METH_W-1:0] unknown_code,
   input  token_type         tok_in,
   input  logic [CNT_W-1:0]  slot_in,
   input  logic [CNT_W-1:0]  total_in,
   output token_type         tok_out,
   output logic [CNT_W-1:0]  slot_out,
   output logic [CNT_W-1:0]  total_out
);

   localparam logic [CNT_W-1:0] IDX = CNT_W'(CELL_INDEX);

   logic [ID_W-1:0]   id_ff;
   logic              en_ff;
   logic              boot_ff;
   logic [METH_W-1:0] meth_ff;

   token_type         tok_ff, tok_in_next;
   logic [CNT_W-1:0]  slot_ff, slot_in_next;
   logic [CNT_W-1:0]  total_ff, total_in_next;

   logic occupied;
   logic hit;
   logic append;
   logic en_next;

   always_comb begin
      occupied = IDX < entry_count;
      hit      = tok_in.active && !tok_in.done && occupied && (id_ff == tok_in.key);
      append   = tok_in.active && !tok_in.done && !occupied && (IDX == entry_count);
      if (hit) begin
         en_next = en_ff | tok_in.en;
      end else if (append) begin
         en_next = tok_in.en;
      end else begin
         en_next = en_ff;
      end

      tok_in_next          = tok_in;
      tok_in_next.done     = tok_in.done | hit | append;
      tok_in_next.appended = tok_in.appended | append;
      slot_in_next         = (hit || append) ? IDX : slot_in;
      // count this slot after its update
      total_in_next        = total_in +
                             CNT_W'((occupied || append) && en_next);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.active <= 1'b0;
      end else begin
         tok_ff   <= tok_in_next;
         slot_ff  <= slot_in_next;
         total_ff <= total_in_next;
      end
   end

   // entry storage, written only by the transaction that hits or fills it
   always_ff @(posedge clock) begin
      if (append) begin
         id_ff   <= tok_in.key;
         en_ff   <= tok_in.en;
         boot_ff <= tok_in.boot;
         meth_ff <= tok_in.meth;
      end else if (hit) begin
         en_ff   <= en_ff | tok_in.en;
         boot_ff <= boot_ff | tok_in.boot;
         if (tok_in.meth != unknown_code) begin
            meth_ff <= tok_in.meth;
         end
      end
   end

   assign tok_out   = tok_ff;
   assign slot_out  = slot_ff;
   assign total_out = total_ff;

endmodule

// File: rtl/cpu_table_insert_or_refresh.sv
// Top level of the processor discovery table: handshake, CSR port and row of cells.
// Depends on ctior_pkg and ctior_cell.
//
//   channel   direction   handshake              payload
//   req_      in          req_valid/req_ready    hardware_id, is_enabled, is_boot_cpu,
//                                                start_method
//   rsp_      out         rsp_valid/rsp_ready    slot_index, table_full, enabled_total
//   csr_      in/out      APB psel/penable       unknown_method_code at byte address 0
//
// A transaction walks the row of TABLE_DEPTH cells, one cell per cycle; the row holds one
// transaction at a time. Reset empties the table at once (entry count to zero); req_ready is
// low during reset. A finished result waits in a holding register while the output
// register is stalled; a new item is taken only once that holding register has drained.
module cpu_table_insert_or_refresh
   import ctior_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [ID_W-1:0]       req_hardware_id,
   input  logic                  req_is_enabled,
   input  logic                  req_is_boot_cpu,
   input  logic [METH_W-1:0]     req_start_method,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [SLOT_W-1:0]     rsp_slot_index,
   output logic                  rsp_table_full,
   output logic [TOTAL_W-1:0]    rsp_enabled_total,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   logic [CNT_W-1:0]  count_ff;
   logic [METH_W-1:0] unknown_ff;
   logic              busy_ff;

   logic              pend_valid_ff;
   logic [SLOT_W-1:0] pend_slot_ff;
   logic              pend_full_ff;
   logic [TOTAL_W-1:0] pend_total_ff;

   logic               rsp_valid_ff;
   logic [SLOT_W-1:0]  rsp_slot_ff;
   logic               rsp_full_ff;
   logic [TOTAL_W-1:0] rsp_total_ff;

   token_type         tok_chain   [TABLE_DEPTH+1];
   logic [CNT_W-1:0]  slot_chain  [TABLE_DEPTH+1];
   logic [CNT_W-1:0]  total_chain [TABLE_DEPTH+1];

   logic req_fire;
   logic pend_move;
   logic csr_write;
   token_type tail;

   assign req_ready = !busy_ff && !reset;
   assign req_fire  = req_valid && req_ready;
   assign pend_move = pend_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      tok_chain[0].active   = req_fire;
      tok_chain[0].done     = 1'b0;
      tok_chain[0].appended = 1'b0;
      tok_chain[0].key      = req_hardware_id;
      tok_chain[0].en       = req_is_enabled;
      tok_chain[0].boot     = req_is_boot_cpu;
      tok_chain[0].meth     = req_start_method;
      slot_chain[0]         = '0;
      total_chain[0]        = '0;
   end

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      ctior_cell #(
         .CELL_INDEX (i),
         .CNT_W      (CNT_W)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .entry_count  (count_ff),
         .unknown_code (unknown_ff),
         .tok_in       (tok_chain[i]),
         .slot_in      (slot_chain[i]),
         .total_in     (total_chain[i]),
         .tok_out      (tok_chain[i+1]),
         .slot_out     (slot_chain[i+1]),
         .total_out    (total_chain[i+1])
      );
   end

   assign tail = tok_chain[TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         count_ff      <= '0;
         unknown_ff    <= '0;
      end else begin
         // hold the row until the result leaves the holding register
         if (req_fire) begin
            busy_ff <= 1'b1;
         end else if (pend_move) begin
            busy_ff <= 1'b0;
         end

         if (tail.active) begin
            pend_valid_ff <= 1'b1;
            pend_slot_ff  <= tail.done ? SLOT_W'(slot_chain[TABLE_DEPTH]) : '0;
            pend_full_ff  <= !tail.done;
            pend_total_ff <= TOTAL_W'(total_chain[TABLE_DEPTH]);
            if (tail.appended) begin
               count_ff <= count_ff + CNT_W'(1);
            end
         end else if (pend_move) begin
            pend_valid_ff <= 1'b0;
         end

         if (pend_move) begin
            rsp_valid_ff <= 1'b1;
            rsp_slot_ff  <= pend_slot_ff;
            rsp_full_ff  <= pend_full_ff;
            rsp_total_ff <= pend_total_ff;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_write) begin
            unique case (csr_reg_type'(csr_paddr[2]))
               REG_UNKNOWN_METHOD: unknown_ff <= csr_pwdata[METH_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_reg_type'(csr_paddr[2]))
         REG_UNKNOWN_METHOD: csr_prdata = CSR_DATA_W'(unknown_ff);
         default: ;
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_slot_index    = rsp_slot_ff;
   assign rsp_table_full    = rsp_full_ff;
   assign rsp_enabled_total = rsp_total_ff;

endmodule

// File: tb/tb.sv
// Testbench for cpu_table_insert_or_refresh: a directed table, then random refresh/insert traffic.
// Results are checked against a table model or typed outcome. Depends on ctior_pkg and the RTL.
module tb;
   import ctior_pkg::*;

   localparam int DEPTH     = DEFAULT_TABLE_DEPTH;
   localparam int SETTLE    = DEPTH + 20;
   localparam int PHASE_LEN = 170;

   typedef struct packed {
      logic [SLOT_W-1:0]  slot;
      logic               full;
      logic [TOTAL_W-1:0] total;
   } outcome_type;

   typedef struct packed {
      logic [ID_W-1:0]   key;
      logic              en;
      logic              boot;
      logic [METH_W-1:0] meth;
      logic              typed;
      outcome_type       want;
   } dir_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [ID_W-1:0]       req_hardware_id;
   logic                  req_is_enabled;
   logic                  req_is_boot_cpu;
   logic [METH_W-1:0]     req_start_method;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [SLOT_W-1:0]     rsp_slot_index;
   logic                  rsp_table_full;
   logic [TOTAL_W-1:0]    rsp_enabled_total;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // table model
   logic [ID_W-1:0]   slot_key  [DEPTH];
   logic              slot_on   [DEPTH];
   logic              slot_boot [DEPTH];
   logic [METH_W-1:0] slot_meth [DEPTH];
   int                slots_used;
   logic [METH_W-1:0] unknown_code;

   outcome_type pending_outcomes[$];
   dir_row_type dir_rows[$];
   int          errors;
   int          sent;
   int          full_seen;
   int          settings;
   bit          calm;

   cpu_table_insert_or_refresh #(.TABLE_DEPTH(DEPTH)) DUT (.*);

   always #2 clock = ~clock;

   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

   function automatic bit stall_roll();
      return !calm && ($urandom_range(99) < 13);
   endfunction

   // Match by id from slot 0 upward; merge on hit, append on miss while room remains.
   function automatic outcome_type lookup_and_merge(logic [ID_W-1:0] key, logic en, logic boot,
                                                    logic [METH_W-1:0] meth);
      outcome_type o;
      int          hit;
      int          on_count;
      hit = -1;
      on_count = 0;
      o.full = 1'b0;
      for (int k = 0; k < slots_used; k++)
         if (hit < 0 && slot_key[k] == key) hit = k;
      if (hit >= 0) begin
         if (en) slot_on[hit] = 1'b1;
         if (boot) slot_boot[hit] = 1'b1;
         if (meth != unknown_code) slot_meth[hit] = meth;
      end else if (slots_used >= DEPTH) begin
         o.full = 1'b1;
         hit = 0;
      end else begin
         hit = slots_used;
         slot_key[hit]  = key;
         slot_on[hit]   = en;
         slot_boot[hit] = boot;
         slot_meth[hit] = meth;
         slots_used++;
      end
      for (int k = 0; k < slots_used; k++)
         if (slot_on[k]) on_count++;
      o.slot  = hit[SLOT_W-1:0];
      o.total = on_count[TOTAL_W-1:0];
      return o;
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
      errors++;
   endtask

   task automatic send_item(logic [ID_W-1:0] key, logic en, logic boot, logic [METH_W-1:0] meth,
                            logic typed, outcome_type want);
      outcome_type predicted;
      @(negedge clock);
      if (stall_roll()) begin
         req_valid <= 1'b0;
         do @(negedge clock); while (stall_roll());
      end
      req_valid        <= 1'b1;
      req_hardware_id  <= key;
      req_is_enabled   <= en;
      req_is_boot_cpu  <= boot;
      req_start_method <= meth;
      do @(posedge clock); while (!req_ready);
      predicted = lookup_and_merge(key, en, boot, meth);
      pending_outcomes.push_back(typed ? want : predicted);
      sent++;
   endtask

   task automatic quiet_sender();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic drain();
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Write the unknown method code, then read it back.
   task automatic set_unknown_code(logic [METH_W-1:0] code);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {REG_UNKNOWN_METHOD, 2'b00};
      csr_pwdata  <= {{(CSR_DATA_W-METH_W){1'b0}}, code};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      unknown_code = code;
      settings++;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[METH_W-1:0] != code) report("csr readback", csr_prdata[METH_W-1:0], code);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic dir_row_type row(logic [ID_W-1:0] key, logic en, logic boot,
                                       logic [METH_W-1:0] meth, logic typed, int slot, bit full,
                                       int total);
      dir_row_type r;
      r.key        = key;
      r.en         = en;
      r.boot       = boot;
      r.meth       = meth;
      r.typed      = typed;
      r.want.slot  = slot[SLOT_W-1:0];
      r.want.full  = full;
      r.want.total = total[TOTAL_W-1:0];
      return r;
   endfunction

   always @(negedge clock)
      rsp_ready <= !reset && !stall_roll();

   always @(posedge clock) begin : rsp_check
      outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            report("unexpected result, slot", rsp_slot_index, 0);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_slot_index != want.slot) report("slot_index", rsp_slot_index, want.slot);
            if (rsp_table_full != want.full) report("table_full", rsp_table_full, want.full);
            if (rsp_enabled_total != want.total)
               report("enabled_total", rsp_enabled_total, want.total);
            if (rsp_table_full) full_seen++;
         end
      end
   end

   initial begin
      logic [ID_W-1:0]   key;
      logic [METH_W-1:0] meth;
      logic [METH_W-1:0] phase_codes [5];
      int                pick;
      dir_row_type       r;

      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_hardware_id = '0;
      req_is_enabled = 1'b0;
      req_is_boot_cpu = 1'b0;
      req_start_method = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      errors = 0;
      sent = 0;
      full_seen = 0;
      settings = 0;
      calm = 1'b0;
      slots_used = 0;
      unknown_code = '0;
      for (int k = 0; k < DEPTH; k++) begin
         slot_key[k] = '0;
         slot_on[k] = 1'b0;
         slot_boot[k] = 1'b0;
         slot_meth[k] = '0;
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_unknown_code(8'h00);

      // extremes of the id, refresh with the unknown code, then fill to the last slot
      dir_rows.push_back(row(64'h0, 1'b0, 1'b0, 8'h00, 1'b1, 0, 1'b0, 0));
      dir_rows.push_back(row({ID_W{1'b1}}, 1'b1, 1'b1, 8'hFF, 1'b1, 1, 1'b0, 1));
      dir_rows.push_back(row(64'h0, 1'b1, 1'b0, 8'h00, 1'b1, 0, 1'b0, 2));
      dir_rows.push_back(row(64'h0, 1'b0, 1'b1, 8'h05, 1'b1, 0, 1'b0, 2));
      dir_rows.push_back(row({ID_W{1'b1}}, 1'b0, 1'b0, 8'h00, 1'b1, 1, 1'b0, 2));
      dir_rows.push_back(row(64'h8000_0000_0000_0000, 1'b0, 1'b1, 8'h80, 1'b0, 0, 1'b0, 0));
      dir_rows.push_back(row(64'h0000_0000_0000_0001, 1'b1, 1'b0, 8'h01, 1'b0, 0, 1'b0, 0));
      dir_rows.push_back(row(64'h5555_5555_5555_5555, 1'b0, 1'b0, 8'h55, 1'b0, 0, 1'b0, 0));
      dir_rows.push_back(row(64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b1, 8'hAA, 1'b0, 0, 1'b0, 0));
      dir_rows.push_back(row(64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 8'h7F, 1'b0, 0, 1'b0, 0));
      dir_rows.push_back(row(64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b0, 8'hFE, 1'b0, 0, 1'b0, 0));
      dir_rows.push_back(row(64'h0000_0001_0000_0000, 1'b0, 1'b0, 8'h10, 1'b0, 0, 1'b0, 0));
      dir_rows.push_back(row(64'h0000_0000_FFFF_FFFF, 1'b1, 1'b0, 8'h20, 1'b0, 0, 1'b0, 0));
      dir_rows.push_back(row(64'hFFFF_FFFF_0000_0000, 1'b0, 1'b1, 8'h30, 1'b0, 0, 1'b0, 0));
      dir_rows.push_back(row(64'h0123_4567_89AB_CDEF, 1'b1, 1'b0, 8'h40, 1'b0, 0, 1'b0, 0));
      dir_rows.push_back(row(64'hFEDC_BA98_7654_3210, 1'b0, 1'b0, 8'h50, 1'b0, 0, 1'b0, 0));
      dir_rows.push_back(row(64'h0000_0000_0000_0002, 1'b0, 1'b0, 8'h60, 1'b0, 0, 1'b0, 0));
      dir_rows.push_back(row(64'h0000_0000_0000_0003, 1'b1, 1'b1, 8'h70, 1'b0, 0, 1'b0, 0));
      dir_rows.push_back(row(64'hDEAD_0000_0000_BEEF, 1'b0, 1'b0, 8'h90, 1'b0, 15, 1'b0, 0));
      // table is now full: a new id is refused, stored ids still refresh
      dir_rows.push_back(row(64'h0000_0000_0000_0004, 1'b1, 1'b0, 8'h11, 1'b0, 0, 1'b1, 0));
      dir_rows.push_back(row(64'hDEAD_0000_0000_BEEF, 1'b1, 1'b0, 8'h00, 1'b0, 0, 1'b0, 0));
      dir_rows.push_back(row({ID_W{1'b1}}, 1'b1, 1'b0, 8'h22, 1'b0, 0, 1'b0, 0));
      foreach (dir_rows[i]) begin
         r = dir_rows[i];
         send_item(r.key, r.en, r.boot, r.meth, r.typed, r.want);
      end
      quiet_sender();
      drain();

      phase_codes[0] = 8'hFF;
      phase_codes[1] = METH_W'($urandom);
      phase_codes[2] = 8'h00;
      phase_codes[3] = 8'h80;
      phase_codes[4] = METH_W'($urandom);
      for (int p = 0; p < 5; p++) begin
         set_unknown_code(phase_codes[p]);
         calm = (p == 2);
         for (int i = 0; i < PHASE_LEN; i++) begin
            if (p == 1 && i == PHASE_LEN / 2) begin
               // hold off until the block has returned everything
               quiet_sender();
               while (pending_outcomes.size() != 0) @(posedge clock);
            end
            pick = $urandom_range(99);
            if (pick < 70) begin
               key = slot_key[$urandom_range(slots_used - 1)];
            end else if (pick < 85) begin
               key = {$urandom, $urandom};
            end else begin
               key = slot_key[$urandom_range(slots_used - 1)];
               key[$urandom_range(ID_W - 1)] ^= 1'b1;
            end
            meth = ($urandom_range(99) < 35) ? unknown_code : METH_W'($urandom);
            // keep enables rare so the enabled count climbs slowly
            send_item(key, $urandom_range(29) == 0, 1'($urandom_range(1)), meth, 1'b0, '0);
         end
         quiet_sender();
         drain();
      end
      calm = 1'b0;

      $display("ran %0d transactions over %0d unknown-code settings; %0d met a full table",
               sent, settings, full_seen);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
